@@ sv/sud64_pkg.sv @@
`timescale 1ns / 1ps
package sud64_pkg;
   localparam int DEF_DATA_WIDTH = 64;
   localparam int FIELD_WIDTH = 64;
   localparam int REQ_TDATA_WIDTH = 136;
   localparam int RSP_TDATA_WIDTH = 128;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_UNSIGNED = 1'b0,
      OP_SIGNED   = 1'b1
   } op_type;
endpackage

@@ sv/sud64_front.sv @@
`timescale 1ns / 1ps
// Front end: takes requests, masks operands, takes magnitudes and records the
// sign fixups, then pushes the classified word into a two-entry queue.
module sud64_front #(
   parameter int DATA_WIDTH = sud64_pkg::DEF_DATA_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] operation, [64:1] dividend, [128:65] divisor, zero fill
   input  logic [sud64_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                                 q_valid,
   input  logic                                 q_ready,
   output logic [DATA_WIDTH-1:0]                q_num,
   output logic [DATA_WIDTH-1:0]                q_den,
   output logic                                 q_zero,
   output logic                                 q_neg_quo,
   output logic                                 q_neg_rem
);
   import sud64_pkg::*;

   localparam int EW = 2 * DATA_WIDTH + 3;

   logic [DATA_WIDTH-1:0] n, d, an, ad;
   logic                  sgn, n_neg, d_neg;
   logic [EW-1:0]         entry;
   logic [EW-1:0]         mem_ff [QUEUE_DEPTH];
   logic [EW-1:0]         head;
   logic                  wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  push, pop;

   // Classify
   always_comb begin
      sgn   = (op_type'(req_tdata[0]) == OP_SIGNED);
      n     = req_tdata[DATA_WIDTH:1];
      d     = req_tdata[FIELD_WIDTH + DATA_WIDTH:FIELD_WIDTH + 1];
      n_neg = sgn & n[DATA_WIDTH-1];
      d_neg = sgn & d[DATA_WIDTH-1];
      an    = n_neg ? (~n + 1'b1) : n;
      ad    = d_neg ? (~d + 1'b1) : d;
      entry = {an, ad, (d == '0), n_neg ^ d_neg, n_neg};
   end

   assign req_tready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign pop        = q_valid & q_ready;
   assign head       = mem_ff[rd_ff];
   assign {q_num, q_den, q_zero, q_neg_quo, q_neg_rem} = head;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= entry;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

@@ sv/sud64_back.sv @@
`timescale 1ns / 1ps
// Back end: one restoring step per stage, DATA_WIDTH stages, then sign
// fixup and a two-entry skid at the output. Pipeline moves when the skid
// is empty, holds one word and the last stage is not valid, or is popped.
module sud64_back #(
   parameter int DATA_WIDTH = sud64_pkg::DEF_DATA_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   output logic                                 q_ready,
   input  logic [DATA_WIDTH-1:0]                q_num,
   input  logic [DATA_WIDTH-1:0]                q_den,
   input  logic                                 q_zero,
   input  logic                                 q_neg_quo,
   input  logic                                 q_neg_rem,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [63:0] quotient, [127:64] remainder
   output logic [sud64_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import sud64_pkg::*;

   localparam int S = DATA_WIDTH;

   // Per stage: num shifts out high bits, quotient bits shift in
   logic [S-1:0]          v_ff;
   logic [DATA_WIDTH-1:0] num_ff [S];
   logic [DATA_WIDTH-1:0] rem_ff [S];
   logic [DATA_WIDTH-1:0] den_ff [S];
   logic [2:0]            flg_ff [S];
   logic [DATA_WIDTH-1:0] num_in [S];
   logic [DATA_WIDTH-1:0] rem_in [S];
   logic                  adv;

   // Two-entry output skid; the stages stall when it cannot take a word
   logic [RSP_TDATA_WIDTH-1:0] out_ff [2];
   logic                       ow_ff, or_ff;
   logic [1:0]                 ocnt_ff, ocnt_in;
   logic                       opush, opop;
   logic [DATA_WIDTH-1:0]      qf, rf;
   logic [2:0]                 lf;

   assign adv     = (ocnt_ff == 2'd0) | ((ocnt_ff == 2'd1) & ~v_ff[S-1]) | opop;
   assign q_ready = adv;

   // Restoring step per stage
   always_comb begin
      for (int i = 0; i < S; i++) begin
         logic [DATA_WIDTH:0]   t;
         logic [DATA_WIDTH-1:0] srcn, srcr, srcd;
         srcn = (i == 0) ? q_num : num_ff[i > 0 ? i - 1 : 0];
         srcr = (i == 0) ? '0 : rem_ff[i > 0 ? i - 1 : 0];
         srcd = (i == 0) ? q_den : den_ff[i > 0 ? i - 1 : 0];
         t    = {srcr, srcn[DATA_WIDTH-1]};
         if (t >= {1'b0, srcd}) begin
            t         = t - {1'b0, srcd};
            num_in[i] = {srcn[DATA_WIDTH-2:0], 1'b1};
         end else begin
            num_in[i] = {srcn[DATA_WIDTH-2:0], 1'b0};
         end
         rem_in[i] = t[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < S; i++) begin
            num_ff[i] <= num_in[i];
            rem_ff[i] <= rem_in[i];
            den_ff[i] <= (i == 0) ? q_den : den_ff[i > 0 ? i - 1 : 0];
            flg_ff[i] <= (i == 0) ? {q_zero, q_neg_quo, q_neg_rem}
                                  : flg_ff[i > 0 ? i - 1 : 0];
         end
      end
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[S-2:0], q_valid};
      end
   end

   // Sign fixup and zero divisor
   always_comb begin
      lf = flg_ff[S-1];
      qf = lf[1] ? (~num_ff[S-1] + 1'b1) : num_ff[S-1];
      rf = lf[0] ? (~rem_ff[S-1] + 1'b1) : rem_ff[S-1];
      if (lf[2]) begin
         qf = '0;
         rf = '0;
      end
   end

   assign opush      = adv & v_ff[S-1];
   assign rsp_tvalid = (ocnt_ff != 2'd0);
   assign opop       = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = out_ff[or_ff];
   assign ocnt_in    = ocnt_ff + 2'(opush) - 2'(opop);

   always_ff @(posedge clock) begin
      if (opush) begin
         out_ff[ow_ff] <= {FIELD_WIDTH'(rf), FIELD_WIDTH'(qf)};
      end
      if (reset) begin
         ow_ff   <= 1'b0;
         or_ff   <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         ow_ff   <= ow_ff ^ opush;
         or_ff   <= or_ff ^ opop;
         ocnt_ff <= ocnt_in;
      end
   end
endmodule

@@ sv/signed_unsigned_divider_64_unit.sv @@
`timescale 1ns / 1ps
// Signed/unsigned 64-bit divider. One request per cycle is accepted while
// the queue has room; each word passes a front stage and a two-entry queue,
// then DATA_WIDTH restoring stages (one quotient bit per stage) and a
// two-entry output buffer that can hold back the stages. Signed results
// truncate toward zero, the remainder follows the dividend sign, a zero
// divisor returns zero for both, and the most negative value over -1 wraps.
module signed_unsigned_divider_64_unit #(
   parameter int DATA_WIDTH = sud64_pkg::DEF_DATA_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] operation, [64:1] dividend, [128:65] divisor, zero fill
   input  logic [sud64_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [63:0] quotient, [127:64] remainder
   output logic [sud64_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import sud64_pkg::*;

   logic                  q_valid, q_ready, q_zero, q_neg_quo, q_neg_rem;
   logic [DATA_WIDTH-1:0] q_num, q_den;

   sud64_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_ready, .q_num, .q_den, .q_zero, .q_neg_quo, .q_neg_rem
   );

   sud64_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_num, .q_den, .q_zero,
      .q_neg_quo, .q_neg_rem, .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

@@ verif/signed_unsigned_divider_64_unit_checker.sv @@
`timescale 1ns / 1ps
module signed_unsigned_divider_64_unit_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [sud64_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [sud64_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output int                                    fail_count,
   output int                                    pending_count,
   output int                                    result_count
);
   import sud64_pkg::*;

   typedef struct packed {
      logic [63:0] remainder;
      logic [63:0] quotient;
   } div_result_type;

   div_result_type quot_rem_q[$];

   // magnitude division, one quotient bit per step
   function automatic div_result_type divide_magnitudes(logic [63:0] num,
                                                        logic [63:0] den);
      div_result_type res;
      logic [64:0] part;
      part = '0;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         part = {part[63:0], num[b]};
         if (part >= {1'b0, den}) begin
            part = part - {1'b0, den};
            res.quotient[b] = 1'b1;
         end
      end
      res.remainder = part[63:0];
      return res;
   endfunction

   function automatic div_result_type predict_division(op_type op, logic [63:0] n,
                                                       logic [63:0] d);
      div_result_type res;
      logic n_neg, d_neg;
      res = '0;
      n_neg = (op == OP_SIGNED) && n[63];
      d_neg = (op == OP_SIGNED) && d[63];
      if (d != 64'd0) begin
         res = divide_magnitudes(n_neg ? -n : n, d_neg ? -d : d);
         if (n_neg != d_neg) res.quotient = -res.quotient;
         if (n_neg) res.remainder = -res.remainder;
      end
      return res;
   endfunction

   assign pending_count = quot_rem_q.size();

   always @(posedge clock) begin
      div_result_type want, got;
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
      end else begin
         // incoming word: queue its expected result
         if (req_tvalid && req_tready)
            quot_rem_q.push_back(predict_division(op_type'(req_tdata[0]),
                                 req_tdata[64:1], req_tdata[128:65]));
         // outgoing word: compare with oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            result_count <= result_count + 1;
            if (quot_rem_q.size() == 0) begin
               $display("%0t: unexpected result q=%h r=%h", $time,
                        got.quotient, got.remainder);
               fail_count <= fail_count + 1;
            end else begin
               want = quot_rem_q.pop_front();
               if (got.quotient !== want.quotient) begin
                  $display("%0t: quotient expected %h actual %h", $time,
                           want.quotient, got.quotient);
                  fail_count <= fail_count + 1;
               end else if (got.remainder !== want.remainder) begin
                  $display("%0t: remainder expected %h actual %h", $time,
                           want.remainder, got.remainder);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ verif/signed_unsigned_divider_64_unit_tb.sv @@
`timescale 1ns / 1ps
module signed_unsigned_divider_64_unit_tb;
   import sud64_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   int fail_count, pending_count, result_count;
   int sent_count = 0;
   logic stim_done = 1'b0;

   always #6 clock = ~clock;

   signed_unsigned_divider_64_unit dut (.*);

   signed_unsigned_divider_64_unit_checker chk (.*);

   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONES = '1;

   // gap length: mostly none or short, sometimes long
   function automatic int gap_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 90);
   endfunction

   function automatic logic [63:0] operand_value();
      case ($urandom_range(0, 7))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 20));
         2: return -64'($urandom_range(1, 20));
         3: return {32'd0, $urandom} >> $urandom_range(0, 31);
         4: return {$urandom, $urandom} >> $urandom_range(0, 63);
         5: return MOST_NEG;
         6: return ALL_ONES;
         default: return 64'd0;
      endcase
   endfunction

   // present one word and hold it until accepted
   task automatic send_division(op_type op, logic [63:0] n, logic [63:0] d);
      repeat (gap_cycles()) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, d, n, op};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // receiver stalls at random, with quiet stretches
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : gap_cycles();
         rsp_tready <= 1'b0;
         repeat (stall) @(negedge clock);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
   end

   initial begin
      logic [63:0] dir_n[12] = '{64'd100, 64'd7, MOST_NEG, MOST_NEG, ALL_ONES,
                                 MOST_POS, 64'd5, ALL_ONES, MOST_NEG, 64'd0,
                                 -64'd7, 64'd7};
      logic [63:0] dir_d[12] = '{64'd7, 64'd0, ALL_ONES, 64'd1, 64'd1, MOST_NEG,
                                 ALL_ONES, ALL_ONES, MOST_NEG, 64'd3, 64'd2,
                                 -64'd2};
      op_type op;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // directed corners in both modes
      for (int i = 0; i < 12; i++) begin
         send_division(OP_UNSIGNED, dir_n[i], dir_d[i]);
         send_division(OP_SIGNED, dir_n[i], dir_d[i]);
      end
      for (int i = 0; i < 1500; i++) begin
         op = op_type'($urandom_range(0, 1));
         send_division(op, operand_value(),
                       ($urandom_range(0, 30) == 0) ? 64'd0 : operand_value());
      end
      @(negedge clock) req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      wait (pending_count == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d division words (signed and unsigned, corner operands),",
               sent_count);
      $display("checked %0d results with random stalls on both channels.", result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout after %0d results", result_count);
      $display("Regression FAIL");
      $finish;
   end
endmodule

@@ files.f @@
sv/sud64_pkg.sv
sv/sud64_front.sv
sv/sud64_back.sv
sv/signed_unsigned_divider_64_unit.sv
verif/signed_unsigned_divider_64_unit_checker.sv
verif/signed_unsigned_divider_64_unit_tb.sv
